>>> rtl/csrau_pkg.sv
// Package: CSR access unit operation codes, address map constants and decode functions.
`default_nettype none

package csrau_pkg;

   typedef logic [2:0]  kind_type;
   typedef logic [11:0] csr_addr_type;
   typedef logic [1:0]  level_type;

   // Operation codes
   localparam kind_type KIND_RW   = 3'd0;
   localparam kind_type KIND_SET  = 3'd1;
   localparam kind_type KIND_CLR  = 3'd2;
   localparam kind_type KIND_RWI  = 3'd3;
   localparam kind_type KIND_SETI = 3'd4;
   localparam kind_type KIND_CLRI = 3'd5;

   // Privilege levels and modes
   localparam level_type LVL_USER  = 2'd0;
   localparam level_type LVL_SUPER = 2'd1;
   localparam level_type LVL_HYPER = 2'd2;
   localparam level_type LVL_MACH  = 2'd3;

   localparam level_type MODE_USER  = 2'd0;
   localparam level_type MODE_SUPER = 2'd1;
   localparam level_type MODE_MACH  = 2'd3;

   // Addresses
   localparam csr_addr_type ADDR_SATP      = 12'h180;
   localparam csr_addr_type ADDR_MSTATUS   = 12'h300;
   localparam int unsigned  TVM_BIT        = 20;

   localparam csr_addr_type ADDR_USER_END  = 12'h0FF;
   localparam csr_addr_type ADDR_SUPER_END = 12'h1FF;
   localparam csr_addr_type ADDR_HYPER_END = 12'h2FF;
   localparam csr_addr_type ADDR_MACH_END  = 12'h3FF;
   localparam csr_addr_type ADDR_MCNT_LO   = 12'hB00;
   localparam csr_addr_type ADDR_MCNT_HI   = 12'hBFF;
   localparam csr_addr_type ADDR_UCNT_LO   = 12'hC00;
   localparam csr_addr_type ADDR_UCNT_HI   = 12'hCFF;
   localparam csr_addr_type ADDR_MID_LO    = 12'hF00;
   localparam csr_addr_type ADDR_ROID_LO   = 12'hF11;
   localparam csr_addr_type ADDR_ROID_HI   = 12'hF15;
   localparam csr_addr_type ADDR_ROCNT_END = 12'hC1F;
   localparam csr_addr_type ADDR_ROCNTH_LO = 12'hC80;
   localparam csr_addr_type ADDR_ROCNTH_HI = 12'hC9F;

   function automatic level_type level_of(input csr_addr_type a);
      level_type lvl;
      if (a <= ADDR_USER_END) begin
         lvl = LVL_USER;
      end else if (a <= ADDR_SUPER_END) begin
         lvl = LVL_SUPER;
      end else if (a <= ADDR_HYPER_END) begin
         lvl = LVL_HYPER;
      end else if (a <= ADDR_MACH_END) begin
         lvl = LVL_MACH;
      end else if (a >= ADDR_MCNT_LO && a <= ADDR_MCNT_HI) begin
         lvl = LVL_MACH;
      end else if (a >= ADDR_UCNT_LO && a <= ADDR_UCNT_HI) begin
         lvl = LVL_USER;
      end else if (a >= ADDR_MID_LO) begin
         lvl = LVL_MACH;
      end else begin
         lvl = LVL_USER;
      end
      return lvl;
   endfunction

   function automatic logic mode_admits(input level_type lvl, input level_type mode);
      logic ok;
      case (lvl)
         LVL_MACH:  ok = (mode == MODE_MACH);
         LVL_SUPER: ok = (mode == MODE_MACH) || (mode == MODE_SUPER);
         LVL_USER:  ok = (mode == MODE_MACH) || (mode == MODE_SUPER) || (mode == MODE_USER);
         default:   ok = 1'b1;
      endcase
      return ok;
   endfunction

   function automatic logic read_only(input csr_addr_type a);
      return (a >= ADDR_ROID_LO   && a <= ADDR_ROID_HI)   ||
             (a >= ADDR_UCNT_LO   && a <= ADDR_ROCNT_END) ||
             (a >= ADDR_ROCNTH_LO && a <= ADDR_ROCNTH_HI);
   endfunction

endpackage

`default_nettype wire

>>> rtl/csr_access_unit_top.sv
// Top level: CSR access unit with a 4096-entry CSR memory and read-modify-write execute stage.
// A beat accepted at a clock edge shows its result (rsp_strobe high) in the next cycle.
// Throughput: one beat per cycle while not busy; the read-modify-write of the CSR memory is
//   closed by forwarding the last written entry to the following beat.
// Reset: synchronous; after reset a clearing pass writes zero to all 4096 entries, one per
//   cycle, with busy high until it ends; no beat is accepted meanwhile.
// The receiver cannot stall: each result is valid for exactly the one strobe cycle.
`default_nettype none

module csr_access_unit_top #(
   parameter int XLEN = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [2:0]                   req_kind,
   input  wire  [11:0]                  req_csr_addr,
   input  wire  [1:0]                   req_priv_mode,
   input  wire  [63:0]                  req_src_value,
   input  wire  [4:0]                   req_rs1_field,
   input  wire  [4:0]                   req_rd_field,
   output logic                         rsp_strobe,
   output logic                         rsp_trap,
   output logic [63:0]                  rsp_read_value,
   output logic                         rsp_rd_write,
   output logic [4:0]                   rsp_rd_index
);

   import csrau_pkg::*;

   localparam int DEPTH  = 4096;
   localparam int AW     = $clog2(DEPTH);

   // CSR memory: one write port, one registered read port
   logic [XLEN-1:0] csr_mem [DEPTH];

   // Clearing pass after reset
   logic          clearing_ff;
   logic [AW-1:0] clr_idx_ff;

   // Execute stage holds the accepted beat while its read data returns
   logic           ex_valid_ff;
   kind_type       ex_kind_ff;
   csr_addr_type   ex_addr_ff;
   level_type      ex_mode_ff;
   logic [XLEN-1:0] ex_src_ff;
   logic [4:0]     ex_rs1_ff;
   logic [4:0]     ex_rd_ff;
   logic [XLEN-1:0] rdata_ff;

   // Forwarding of the entry written at the edge the current beat was read
   logic            fwd_valid_ff;
   csr_addr_type    fwd_addr_ff;
   logic [XLEN-1:0] fwd_data_ff;

   // Shadow of mstatus.TVM, kept in step with writes to mstatus
   logic tvm_ff;

   logic            accept;
   logic            writes;
   logic            trap;
   logic            wr_en;
   logic [XLEN-1:0] old_value;
   logic [XLEN-1:0] operand;
   logic [XLEN-1:0] new_value_in;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [XLEN-1:0] mem_wdata;

   assign busy   = clearing_ff;
   assign accept = start && !busy;

   // Pick up the value written at the edge this beat's read was issued
   assign old_value = (fwd_valid_ff && (fwd_addr_ff == ex_addr_ff)) ? fwd_data_ff : rdata_ff;

   always_comb begin
      writes = (ex_kind_ff == KIND_RW) || (ex_kind_ff == KIND_RWI) || (ex_rs1_ff != 5'd0);
      if (ex_kind_ff > KIND_CLRI) begin
         trap = 1'b1;
      end else if (ex_mode_ff == MODE_SUPER && tvm_ff && ex_addr_ff == ADDR_SATP) begin
         trap = 1'b1;
      end else if (!mode_admits(level_of(ex_addr_ff), ex_mode_ff)) begin
         trap = 1'b1;
      end else if (read_only(ex_addr_ff) && writes) begin
         trap = 1'b1;
      end else begin
         trap = 1'b0;
      end
   end

   // Immediate forms take the zero-extended rs1 field as operand
   assign operand = (ex_kind_ff >= KIND_RWI) ? XLEN'(ex_rs1_ff) : ex_src_ff;

   always_comb begin
      case (ex_kind_ff)
         KIND_RW, KIND_RWI:   new_value_in = operand;
         KIND_SET, KIND_SETI: new_value_in = old_value | operand;
         default:             new_value_in = old_value & ~operand;
      endcase
   end

   // Register rw with rs1 zero is checked as a write but leaves the entry alone
   assign wr_en = ex_valid_ff && !trap && ((ex_kind_ff == KIND_RWI) || (ex_rs1_ff != 5'd0));

   // Clearing pass owns the write port until it ends
   assign mem_we    = clearing_ff || wr_en;
   assign mem_waddr = clearing_ff ? clr_idx_ff : ex_addr_ff;
   assign mem_wdata = clearing_ff ? '0 : new_value_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         csr_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rdata_ff <= csr_mem[req_csr_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         ex_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         tvm_ff       <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         ex_valid_ff  <= accept;
         fwd_valid_ff <= wr_en;
         if (wr_en && ex_addr_ff == ADDR_MSTATUS) begin
            tvm_ff <= new_value_in[TVM_BIT];
         end
      end
   end

   // Payload: hold the accepted beat and the last written entry
   always_ff @(posedge clock) begin
      if (accept) begin
         ex_kind_ff <= req_kind;
         ex_addr_ff <= req_csr_addr;
         ex_mode_ff <= req_priv_mode;
         ex_src_ff  <= req_src_value[XLEN-1:0];
         ex_rs1_ff  <= req_rs1_field;
         ex_rd_ff   <= req_rd_field;
      end
      fwd_addr_ff <= ex_addr_ff;
      fwd_data_ff <= new_value_in;
   end

   // Result drive: old value on success, zero on trap
   assign rsp_strobe     = ex_valid_ff;
   assign rsp_trap       = trap;
   assign rsp_read_value = trap ? 64'd0 : 64'(old_value);
   assign rsp_rd_write   = !trap && (ex_rd_ff != 5'd0);
   assign rsp_rd_index   = ex_rd_ff;

   // Every accepted beat yields a strobe in the next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> rsp_strobe)
      else $error("accepted beat produced no result");

   // No result may appear while the clearing pass runs
   assert property (@(posedge clock) disable iff (reset) clearing_ff |-> !ex_valid_ff)
      else $error("result during clearing pass");

   // Clearing ends only after the last entry was written
   assert property (@(posedge clock) disable iff (reset)
         $fell(clearing_ff) |-> $past(clr_idx_ff) == AW'(DEPTH - 1))
      else $error("clearing pass ended early");

   // The TVM shadow moves only on a write to mstatus
   assert property (@(posedge clock) disable iff (reset)
         !(wr_en && ex_addr_ff == ADDR_MSTATUS) |=> $stable(tvm_ff))
      else $error("TVM shadow changed without mstatus write");

endmodule

`default_nettype wire
